### src/hts_pkg.sv
`default_nettype none

package hts_pkg;

    localparam int POS_W = 24;
    localparam int TAG_W = 16;
    localparam int OUT_LEVEL_W = 6;

    localparam logic [7:0] CH_LT    = 8'h3C;
    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_QUOTE = 8'h22;

    // Keys are packed first character in the low byte: id=" and class="
    localparam int KEY_ID_LEN    = 4;
    localparam int KEY_CLASS_LEN = 7;
    localparam logic [8*KEY_ID_LEN-1:0]    KEY_ID    = 32'h223D_6469;
    localparam logic [8*KEY_CLASS_LEN-1:0] KEY_CLASS = 56'h22_3D73_7361_6C63;

    typedef struct packed {
        logic             found;
        logic [POS_W-1:0] start;
        logic [POS_W-1:0] len;
    } t_scan_status;

    typedef struct packed {
        logic clear;
        logic write;
    } t_tbl_ctl;

endpackage

`default_nettype wire

### src/hts_key_match.sv
`default_nettype none

module hts_key_match #(
    parameter int KEY_LEN = 4,
    parameter logic [8*KEY_LEN-1:0] KEY = 32'h223D_6469
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_step,
    input  wire logic                      i_clear,
    input  wire logic                      i_enable,
    input  wire logic [7:0]                i_byte,
    input  wire logic [hts_pkg::POS_W-1:0] i_pos,
    output hts_pkg::t_scan_status          o_status
);

    localparam int PW = $clog2(KEY_LEN + 1);

    localparam logic [1:0] PH_SEARCH  = 2'd0;
    localparam logic [1:0] PH_CAPTURE = 2'd1;
    localparam logic [1:0] PH_FOUND   = 2'd2;

    logic [PW-1:0]             r_prog, n_prog;
    logic [1:0]                r_phase, n_phase;
    logic [hts_pkg::POS_W-1:0] r_start, n_start;
    logic [hts_pkg::POS_W-1:0] r_len, n_len;

    always_comb begin
        n_prog  = r_prog;
        n_phase = r_phase;
        n_start = r_start;
        n_len   = r_len;
        if (i_step) begin
            if (i_clear) begin
                n_prog  = '0;
                n_phase = PH_SEARCH;
                n_start = '0;
                n_len   = '0;
            end else if (i_enable) begin
                case (r_phase)
                    PH_SEARCH: begin
                        if (i_byte == KEY[8*r_prog +: 8]) begin
                            n_prog = r_prog + PW'(1);
                        end else if (i_byte == KEY[7:0]) begin
                            n_prog = PW'(1);
                        end else begin
                            n_prog = '0;
                        end
                        // full key seen: value starts after the quote
                        if (n_prog == PW'(KEY_LEN)) begin
                            n_prog  = '0;
                            n_phase = PH_CAPTURE;
                            n_start = i_pos + hts_pkg::POS_W'(1);
                        end
                    end
                    PH_CAPTURE: begin
                        if (i_byte == hts_pkg::CH_QUOTE) begin
                            n_len   = i_pos - r_start;
                            n_phase = PH_FOUND;
                        end
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prog  <= '0;
            r_phase <= PH_SEARCH;
        end else begin
            r_prog  <= n_prog;
            r_phase <= n_phase;
        end
        r_start <= n_start;
        r_len   <= n_len;
    end

    assign o_status.found = (r_phase == PH_FOUND);
    assign o_status.start = r_start;
    assign o_status.len   = r_len;

    a_prog_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_prog < PW'(KEY_LEN))
        else $error("key match progress out of range");

endmodule

`default_nettype wire

### src/hts_level_table.sv
`default_nettype none

module hts_level_table #(
    parameter int MAX_DEPTH = 64
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  hts_pkg::t_tbl_ctl                   i_ctl,
    input  wire logic [$clog2(MAX_DEPTH)-1:0]   i_wr_level,
    input  wire logic [hts_pkg::TAG_W-1:0]      i_wr_tag,
    input  wire logic [$clog2(MAX_DEPTH)-1:0]   i_next_level,
    input  wire logic [$clog2(MAX_DEPTH)-1:0]   i_cur_level,
    output logic [hts_pkg::TAG_W-1:0]           o_parent
);

    localparam int LW = $clog2(MAX_DEPTH);

    logic [hts_pkg::TAG_W-1:0] r_mem [MAX_DEPTH];
    logic [hts_pkg::TAG_W-1:0] r_rd_data;
    logic [MAX_DEPTH-1:0]      r_valid, n_valid;
    logic [LW-1:0]             rd_addr;
    logic [LW-1:0]             cur_up;

    // Read one level up from the level that holds after this cycle
    assign rd_addr = (i_next_level == '0) ? '0 : i_next_level - LW'(1);
    assign cur_up  = (i_cur_level == '0) ? '0 : i_cur_level - LW'(1);

    always_ff @(posedge i_clk) begin
        if (i_ctl.write) begin
            r_mem[i_wr_level] <= i_wr_tag;
        end
        r_rd_data <= r_mem[rd_addr];
    end

    always_comb begin
        n_valid = i_ctl.clear ? '0 : r_valid;
        if (i_ctl.write) begin
            n_valid[i_wr_level] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            r_valid <= n_valid;
        end
    end

    assign o_parent = (i_cur_level != '0 && r_valid[cur_up]) ? r_rd_data : '0;

    a_write_marks_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.write |=> r_valid[$past(i_wr_level)])
        else $error("written level not marked valid");

endmodule

`default_nettype wire

### src/html_tag_scanner.sv
`default_nettype none

// Channel | Signals                                   | Direction
// in      | i_valid, o_ready, i_text_byte, i_doc_begin | document bytes in
// out     | o_valid, i_ready, o_tag_* and the rest     | one record per tag
//
// One byte per cycle while the output is not stalled: a byte is held in the input
// register, then its record (if any) lands in the output register.
// The level table is read each cycle one level up from the current level;
// two tag ends are always at least two bytes apart, so the read is current.
// Reset (synchronous, active low) clears all counters and the table's valid bits.
// A stalled output holds the input register; nothing is dropped.

module html_tag_scanner #(
    parameter int MAX_DEPTH = 64
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_valid,
    output logic                                     o_ready,
    input  wire logic [7:0]                          i_text_byte,
    input  wire logic                                i_doc_begin,
    output logic                                     o_valid,
    input  wire logic                                i_ready,
    output logic [hts_pkg::TAG_W-1:0]                o_tag_number,
    output logic [hts_pkg::POS_W-1:0]                o_tag_offset,
    output logic [hts_pkg::POS_W-1:0]                o_tag_length,
    output logic [hts_pkg::OUT_LEVEL_W-1:0]          o_tag_level,
    output logic [hts_pkg::TAG_W-1:0]                o_parent_number,
    output logic [hts_pkg::POS_W-1:0]                o_id_offset,
    output logic [hts_pkg::POS_W-1:0]                o_id_length,
    output logic [hts_pkg::POS_W-1:0]                o_class_offset,
    output logic [hts_pkg::POS_W-1:0]                o_class_length,
    output logic                                     o_level_fault
);

    localparam int LW = $clog2(MAX_DEPTH);
    localparam int PW = hts_pkg::POS_W;
    localparam int TW = hts_pkg::TAG_W;

    // input register
    logic        r_in_valid;
    logic [7:0]  r_byte;
    logic        r_begin;

    // scan state
    logic [PW-1:0] r_pos, n_pos;
    logic [TW-1:0] r_tag_cnt, n_tag_cnt;
    logic [LW-1:0] r_level, n_level;
    logic          r_inside, n_inside;
    logic [PW-1:0] r_open, n_open;
    logic          r_closing, n_closing;
    logic [7:0]    r_prev, n_prev;

    // output register
    logic          r_out_valid;
    logic [TW-1:0] r_tag_number, r_parent_number;
    logic [PW-1:0] r_tag_offset, r_tag_length;
    logic [hts_pkg::OUT_LEVEL_W-1:0] r_tag_level;
    logic [PW-1:0] r_id_offset, r_id_length, r_class_offset, r_class_length;
    logic          r_level_fault;

    logic          advance;
    logic          emit;
    logic          is_lt, is_gt;
    logic [PW-1:0] pos;
    logic [TW-1:0] tag_cnt;
    logic [LW-1:0] level;
    logic          in_tag;
    logic [PW-1:0] open_ofs;
    logic          closing;
    logic [7:0]    prev;
    logic [LW+1:0] level_calc;
    logic [LW+1:0] level_dec;
    logic          level_neg, level_over, fault;
    logic [LW+6:0] level_wide;
    logic [TW-1:0] parent;
    logic          scan_clear, scan_enable;
    hts_pkg::t_scan_status id_status, class_status;
    hts_pkg::t_tbl_ctl     tbl_ctl;

    assign advance = r_in_valid && (!r_out_valid || i_ready);
    assign o_ready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_byte  <= i_text_byte;
            r_begin <= i_doc_begin;
        end
    end

    // state as seen by this byte, after an optional document restart
    assign pos      = r_begin ? '0 : r_pos;
    assign tag_cnt  = r_begin ? '0 : r_tag_cnt;
    assign level    = r_begin ? '0 : r_level;
    assign in_tag   = r_begin ? 1'b0 : r_inside;
    assign open_ofs = r_begin ? '0 : r_open;
    assign closing  = r_begin ? 1'b0 : r_closing;
    assign prev     = r_begin ? '0 : r_prev;

    assign is_lt = (r_byte == hts_pkg::CH_LT);
    assign is_gt = (r_byte == hts_pkg::CH_GT);
    assign emit  = in_tag && is_gt;

    assign scan_clear  = r_begin || is_lt;
    assign scan_enable = in_tag && !is_lt && !is_gt;

    // next level: plus one, minus two for a closing tag, minus one for self-closing
    assign level_dec  = (LW+2)'({closing, 1'b0}) + (LW+2)'(prev == hts_pkg::CH_SLASH);
    assign level_calc = (LW+2)'(level) + (LW+2)'(1) - level_dec;
    assign level_neg  = level_calc[LW+1];
    assign level_over = !level_neg && (level_calc > (LW+2)'(MAX_DEPTH - 1));
    assign fault      = level_neg || level_over;
    assign level_wide = (LW+7)'(level);

    always_comb begin
        n_pos     = r_pos;
        n_tag_cnt = r_tag_cnt;
        n_level   = r_level;
        n_inside  = r_inside;
        n_open    = r_open;
        n_closing = r_closing;
        n_prev    = r_prev;
        if (advance) begin
            n_pos     = pos + PW'(1);
            n_prev    = r_byte;
            n_tag_cnt = tag_cnt;
            n_level   = level;
            n_inside  = in_tag;
            n_open    = open_ofs;
            n_closing = closing;
            if (is_lt) begin
                n_inside  = 1'b1;
                n_open    = pos;
                n_closing = 1'b0;
            end else if (emit) begin
                n_inside  = 1'b0;
                n_tag_cnt = tag_cnt + TW'(1);
                if (level_neg) begin
                    n_level = '0;
                end else if (level_over) begin
                    n_level = LW'(MAX_DEPTH - 1);
                end else begin
                    n_level = level_calc[LW-1:0];
                end
            end else if (in_tag && prev == hts_pkg::CH_LT
                         && r_byte == hts_pkg::CH_SLASH) begin
                n_closing = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos     <= '0;
            r_tag_cnt <= '0;
            r_level   <= '0;
            r_inside  <= 1'b0;
            r_open    <= '0;
            r_closing <= 1'b0;
            r_prev    <= '0;
        end else begin
            r_pos     <= n_pos;
            r_tag_cnt <= n_tag_cnt;
            r_level   <= n_level;
            r_inside  <= n_inside;
            r_open    <= n_open;
            r_closing <= n_closing;
            r_prev    <= n_prev;
        end
    end

    hts_key_match #(
        .KEY_LEN (hts_pkg::KEY_ID_LEN),
        .KEY     (hts_pkg::KEY_ID)
    ) u_id_match (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (advance),
        .i_clear  (scan_clear),
        .i_enable (scan_enable),
        .i_byte   (r_byte),
        .i_pos    (pos),
        .o_status (id_status)
    );

    hts_key_match #(
        .KEY_LEN (hts_pkg::KEY_CLASS_LEN),
        .KEY     (hts_pkg::KEY_CLASS)
    ) u_class_match (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (advance),
        .i_clear  (scan_clear),
        .i_enable (scan_enable),
        .i_byte   (r_byte),
        .i_pos    (pos),
        .o_status (class_status)
    );

    assign tbl_ctl.clear = advance && r_begin;
    assign tbl_ctl.write = advance && emit;

    hts_level_table #(
        .MAX_DEPTH (MAX_DEPTH)
    ) u_level_table (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctl        (tbl_ctl),
        .i_wr_level   (level),
        .i_wr_tag     (tag_cnt),
        .i_next_level (n_level),
        .i_cur_level  (level),
        .o_parent     (parent)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= emit;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
        if (advance && emit) begin
            r_tag_number    <= tag_cnt;
            r_tag_offset    <= open_ofs;
            r_tag_length    <= pos - open_ofs + PW'(1);
            r_tag_level     <= (level_wide > (LW+7)'(63)) ? 6'd63 : level_wide[5:0];
            r_parent_number <= parent;
            r_id_offset     <= id_status.found ? id_status.start : '0;
            r_id_length     <= id_status.found ? id_status.len : '0;
            r_class_offset  <= class_status.found ? class_status.start : '0;
            r_class_length  <= class_status.found ? class_status.len : '0;
            r_level_fault   <= fault;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_tag_number    = r_tag_number;
    assign o_tag_offset    = r_tag_offset;
    assign o_tag_length    = r_tag_length;
    assign o_tag_level     = r_tag_level;
    assign o_parent_number = r_parent_number;
    assign o_id_offset     = r_id_offset;
    assign o_id_length     = r_id_length;
    assign o_class_offset  = r_class_offset;
    assign o_class_length  = r_class_length;
    assign o_level_fault   = r_level_fault;

    a_level_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_level <= LW'(MAX_DEPTH - 1))
        else $error("nest level beyond table depth");

    a_tag_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && emit |=> r_tag_cnt == $past(tag_cnt) + TW'(1))
        else $error("tag counter did not advance on record");

    a_restart_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && r_begin |=> r_pos == PW'(1))
        else $error("document restart did not reset byte position");

endmodule

`default_nettype wire
